// ===== rtl/grid_raycast_column_renderer_macros.svh =====
// Assertion macros shared by the checker of the grid ray-cast column renderer.
// Depends on nothing; the using module supplies i_clk and i_rst_n.
`ifndef GRID_RAYCAST_COLUMN_RENDERER_MACROS_SVH
`define GRID_RAYCAST_COLUMN_RENDERER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RGC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgc assertion failed");

// Next-cycle implication, disabled during reset
`define RGC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgc assertion failed");

`endif

// ===== rtl/rgc_pkg.sv =====
// Package of the grid ray-cast column renderer: sizes, codes, command and
// status structs, controller states and the quarter-wave sine table.
package rgc_pkg;

    localparam int SCREEN_COLUMNS = 120;
    localparam int SCREEN_ROWS    = 40;
    localparam int MAP_SIDE       = 16;
    localparam int MAX_STEPS      = 160;
    localparam int SINE_ENTRIES   = 256;

    // One turn in fine angle units, and the fine-to-phase divisor (240)
    localparam int TURN       = 2048 * SCREEN_COLUMNS;
    localparam int PHASE_DIV  = TURN / (4 * SINE_ENTRIES);
    // floor(f/240) = floor((f>>4) * 17477 >> 18) for every f below TURN
    localparam int PHASE_RECIP = 17477;
    localparam int POS_SCALE   = 163840;
    // MAP_SIDE cells in ray units
    localparam longint LIMIT   = longint'(MAP_SIDE) * 256 * POS_SCALE;

    // Glyph codes
    localparam logic [3:0] GLYPH_BLANK = 4'd0;
    localparam logic [3:0] GLYPH_WALL1 = 4'd1;
    localparam logic [3:0] GLYPH_WALL2 = 4'd2;
    localparam logic [3:0] GLYPH_WALL3 = 4'd3;
    localparam logic [3:0] GLYPH_WALL4 = 4'd4;
    localparam logic [3:0] GLYPH_HASH  = 4'd5;
    localparam logic [3:0] GLYPH_X     = 4'd6;
    localparam logic [3:0] GLYPH_DOT   = 4'd7;
    localparam logic [3:0] GLYPH_DASH  = 4'd8;

    // Register indexes
    localparam logic [2:0] REG_PLAYER_X = 3'd0;
    localparam logic [2:0] REG_PLAYER_Y = 3'd1;
    localparam logic [2:0] REG_VIEW     = 3'd2;
    localparam logic [2:0] REG_FOV      = 3'd3;
    localparam logic [2:0] REG_MAP0     = 3'd4;
    localparam logic [2:0] REG_MAP1     = 3'd5;
    localparam logic [2:0] REG_MAP2     = 3'd6;
    localparam logic [2:0] REG_MAP3     = 3'd7;

    localparam int DIV_BITS = 13;

    typedef enum logic [3:0] {
        ST_IDLE, ST_REDUCE, ST_PHASE, ST_DIR, ST_INIT,
        ST_MARCH, ST_DIV_LOAD, ST_DIV, ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic reduce;
        logic phase;
        logic dir;
        logic init;
        logic march;
        logic div_load;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic fine_ok;
        logic march_stop;
        logic div_last;
        logic row_last;
    } t_dp_status;

    typedef logic [14:0] t_sine_lut [0:SINE_ENTRIES];

    // Taylor series of sine in Q2.30, rounded to Q1.14, evaluated at elaboration
    function automatic t_sine_lut build_sine();
        t_sine_lut lut;
        longint unsigned x, x2, t, q;
        longint sum;
        for (int k = 0; k <= SINE_ENTRIES; k++) begin
            x   = (longint'(k) * 64'd1686629713) / SINE_ENTRIES;
            x2  = (x * x) >> 30;
            t   = x;
            sum = longint'(x);
            // Odd terms subtract, even terms add; divisors are (2n)(2n+1)
            t   = ((t * x2) >> 30) / 6;
            sum = sum - longint'(t);
            t   = ((t * x2) >> 30) / 20;
            sum = sum + longint'(t);
            t   = ((t * x2) >> 30) / 42;
            sum = sum - longint'(t);
            t   = ((t * x2) >> 30) / 72;
            sum = sum + longint'(t);
            t   = ((t * x2) >> 30) / 110;
            sum = sum - longint'(t);
            if (sum < 0) sum = 0;
            q = (longint'(sum) + 32768) >> 16;
            if (q > 16384) q = 16384;
            lut[k] = q[14:0];
        end
        return lut;
    endfunction

    localparam t_sine_lut SINE_LUT = build_sine();

    // Full-wave sine of a phase of 4*SINE_ENTRIES per turn, Q1.14 signed
    function automatic logic signed [15:0] sine_of(input logic [9:0] ph);
        logic [1:0] quad;
        logic [8:0] r;
        logic [14:0] mag;
        quad = ph[9:8];
        r    = {1'b0, ph[7:0]};
        if (quad[0]) mag = SINE_LUT[9'(SINE_ENTRIES) - r];
        else mag = SINE_LUT[r];
        if (quad[1]) return -$signed({1'b0, mag});
        return $signed({1'b0, mag});
    endfunction

endpackage

// ===== rtl/grid_raycast_column_renderer.sv =====
// Top level of the grid ray-cast column renderer: controller plus datapath.
// Depends on rgc_pkg, rgc_ctrl and rgc_dp.
//
// Pulse start with a column while busy is low; the block casts that column's
// ray and then drives one result per screen row, top to bottom, on
// consecutive cycles marked by o_valid, with o_last on the bottom row. The
// receiver cannot stall, so results must be taken as they appear. A column
// passes through angle reduction, phase, direction lookup and ray setup,
// march steps (1 to 160) through the wall bitmap, the load and run of the
// shift-subtract ceiling divider and then row emission; the last row is still
// on the outputs after busy has fallen. Write configuration only while busy
// is low.
module grid_raycast_column_renderer import rgc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata,
    input  logic        start,
    input  logic [6:0]  i_column,
    output logic        busy,
    output logic        o_valid,
    output logic [5:0]  o_row,
    output logic [3:0]  o_glyph,
    output logic [7:0]  o_wall_steps,
    output logic        o_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    rgc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    rgc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_column     (i_column),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_row        (o_row),
        .o_glyph      (o_glyph),
        .o_wall_steps (o_wall_steps),
        .o_last       (o_last)
    );

endmodule

// ===== rtl/rgc_ctrl.sv =====
// Controller of the grid ray-cast column renderer: sequences angle setup,
// ray march, ceiling division and row emission. Uses rgc_pkg.
module rgc_ctrl import rgc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (i_status.fine_ok) n_state = ST_PHASE;
            end
            ST_PHASE: begin
                o_cmd.phase = 1'b1;
                n_state     = ST_DIR;
            end
            ST_DIR: begin
                o_cmd.dir = 1'b1;
                n_state   = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = ST_MARCH;
            end
            ST_MARCH: begin
                o_cmd.march = 1'b1;
                if (i_status.march_stop) n_state = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.row_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/rgc_dp.sv =====
// Datapath of the grid ray-cast column renderer: configuration registers,
// angle and direction, ray march, ceiling divider and row glyphs. Uses rgc_pkg.
module rgc_dp import rgc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata,
    input  logic [6:0]  i_column,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic        o_valid,
    output logic [5:0]  o_row,
    output logic [3:0]  o_glyph,
    output logic [7:0]  o_wall_steps,
    output logic        o_last
);

    logic [11:0] r_px, r_py;
    logic [9:0]  r_view, r_fov;
    logic [63:0] r_map [0:3];

    logic [19:0] r_acc;
    logic [9:0]  r_phase;
    logic signed [15:0] r_dx, r_dy;
    logic signed [32:0] r_rx, r_ry;
    logic [7:0]  r_s, r_steps;
    logic        r_neg;
    logic [DIV_BITS-1:0] r_num, r_quo;
    logic [8:0]  r_den, r_rem;
    logic [3:0]  r_div_cnt;
    logic [5:0]  r_row;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= 12'd2048;
            r_py   <= 12'd2048;
            r_view <= '0;
            r_fov  <= 10'd128;
            for (int i = 0; i < 4; i++) r_map[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PLAYER_X: r_px    <= i_cfg_wdata[11:0];
                REG_PLAYER_Y: r_py    <= i_cfg_wdata[11:0];
                REG_VIEW:     r_view  <= i_cfg_wdata[9:0];
                REG_FOV:      r_fov   <= i_cfg_wdata[9:0];
                REG_MAP0:     r_map[0] <= i_cfg_wdata;
                REG_MAP1:     r_map[1] <= i_cfg_wdata;
                REG_MAP2:     r_map[2] <= i_cfg_wdata;
                REG_MAP3:     r_map[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Fine angle before reduction, always non-negative
    logic [20:0] acc_sum;
    assign acc_sum = 21'(r_view * 8'(2 * SCREEN_COLUMNS))
                   + 21'({i_column, 1'b0} * r_fov)
                   + 21'(TURN)
                   - 21'(r_fov * 7'(SCREEN_COLUMNS));

    logic [28:0] phase_prod;
    assign phase_prod = r_acc[17:4] * 15'(PHASE_RECIP);

    // March probe at the current step
    logic        out_map, wall;
    logic [6:0]  vx, vy;
    logic [14:0] px5, py5;
    logic [3:0]  cx, cy;
    logic [63:0] map_row;
    logic signed [32:0] dx_step, dy_step;

    assign out_map = r_rx[32] || r_ry[32] || (r_rx >= 33'(LIMIT)) || (r_ry >= 33'(LIMIT));
    assign vx  = r_rx[29:23];
    assign vy  = r_ry[29:23];
    assign px5 = vx * 8'd205;
    assign py5 = vy * 8'd205;
    assign cx  = px5[13:10];
    assign cy  = py5[13:10];
    assign map_row = r_map[cy[3:2]];
    assign wall    = map_row[{cy[1:0], cx}];
    assign dx_step = {{9{r_dx[15]}}, r_dx, 8'b0};
    assign dy_step = {{9{r_dy[15]}}, r_dy, 8'b0};

    // Ceiling numerator: SCREEN_ROWS*steps - 20*SCREEN_ROWS
    logic signed [13:0] num_s;
    logic [13:0] num_abs;
    assign num_s   = $signed({1'b0, 13'(r_steps * 6'(SCREEN_ROWS))})
                   - 14'(20 * SCREEN_ROWS);
    assign num_abs = num_s[13] ? 14'(-num_s) : 14'(num_s);

    logic [9:0] rem_sh;
    logic       q_bit;
    assign rem_sh = {r_rem, r_num[DIV_BITS-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    // Work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_acc <= acc_sum[19:0];
        if (i_cmd.reduce && !o_status.fine_ok) r_acc <= r_acc - 20'(TURN);
        if (i_cmd.phase) r_phase <= phase_prod[27:18];
        if (i_cmd.dir) begin
            r_dx <= sine_of(r_phase);
            r_dy <= sine_of(r_phase + 10'(SINE_ENTRIES));
        end
        if (i_cmd.init) begin
            r_rx <= $signed({3'b0, 30'(r_px * 18'(POS_SCALE))}) + dx_step;
            r_ry <= $signed({3'b0, 30'(r_py * 18'(POS_SCALE))}) + dy_step;
            r_s  <= 8'd1;
        end
        if (i_cmd.march) begin
            if (o_status.march_stop) begin
                r_steps <= out_map ? 8'(MAX_STEPS) : r_s;
            end else begin
                r_rx <= r_rx + dx_step;
                r_ry <= r_ry + dy_step;
                r_s  <= r_s + 8'd1;
            end
        end
        if (i_cmd.div_load) begin
            r_neg     <= num_s[13];
            r_num     <= num_abs[DIV_BITS-1:0];
            r_den     <= {r_steps, 1'b0};
            r_rem     <= '0;
            r_quo     <= '0;
            r_div_cnt <= 4'(DIV_BITS);
            r_row     <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= q_bit ? 9'(rem_sh - {1'b0, r_den}) : rem_sh[8:0];
            r_num     <= {r_num[DIV_BITS-2:0], 1'b0};
            r_quo     <= {r_quo[DIV_BITS-2:0], q_bit};
            r_div_cnt <= r_div_cnt - 4'd1;
        end
        if (i_cmd.emit) r_row <= r_row + 6'd1;
    end

    assign o_status.fine_ok    = (r_acc < 20'(TURN));
    assign o_status.march_stop = out_map || wall || (r_s == 8'(MAX_STEPS));
    assign o_status.div_last   = (r_div_cnt == 4'd1);
    assign o_status.row_last   = (r_row == 6'(SCREEN_ROWS - 1));

    // Row glyph
    logic signed [14:0] ceil_s, floor_s, row_s;
    logic [6:0]  rem_rows;
    logic [3:0]  wall_glyph, glyph;
    assign ceil_s   = r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});
    assign floor_s  = 15'(SCREEN_ROWS) - ceil_s;
    assign row_s    = $signed({9'b0, r_row});
    assign rem_rows = 7'(SCREEN_ROWS) - {1'b0, r_row};

    always_comb begin
        priority if (r_steps <= 8'd10) wall_glyph = GLYPH_WALL1;
        else if (r_steps < 8'd20) wall_glyph = GLYPH_WALL2;
        else if (r_steps < 8'd40) wall_glyph = GLYPH_WALL3;
        else if (r_steps < 8'd80) wall_glyph = GLYPH_WALL4;
        else wall_glyph = GLYPH_BLANK;
    end

    always_comb begin
        priority if (row_s < ceil_s) glyph = GLYPH_BLANK;
        else if (row_s <= floor_s) glyph = wall_glyph;
        else if (12'(8 * rem_rows) < 12'(SCREEN_ROWS)) glyph = GLYPH_HASH;
        else if (12'(4 * rem_rows) < 12'(SCREEN_ROWS)) glyph = GLYPH_X;
        else if (12'(8 * rem_rows) < 12'(3 * SCREEN_ROWS)) glyph = GLYPH_DOT;
        else if (12'(20 * rem_rows) < 12'(9 * SCREEN_ROWS)) glyph = GLYPH_DASH;
        else glyph = GLYPH_BLANK;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= i_cmd.emit;
        if (i_cmd.emit) begin
            o_row        <= r_row;
            o_glyph      <= glyph;
            o_wall_steps <= r_steps;
            o_last       <= o_status.row_last;
        end
    end

endmodule

// ===== rtl/rgc_checker.sv =====
// Port-level checker for the grid ray-cast column renderer, bound to the top.
// Depends on rgc_pkg and grid_raycast_column_renderer_macros.svh.
`include "grid_raycast_column_renderer_macros.svh"

module rgc_checker import rgc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [5:0] o_row,
    input logic [7:0] o_wall_steps,
    input logic       o_last
);

    // Rows of a column come out back to back in order
    `RGC_ASSERT_NXT(a_row_seq, o_valid && !o_last, o_valid && (o_row == $past(o_row) + 6'd1))
    // The last flag marks the bottom row only
    `RGC_ASSERT_IMP(a_last_row, o_valid, o_last == (o_row == 6'(SCREEN_ROWS - 1)))
    // Step count stays fixed across a column
    `RGC_ASSERT_IMP(a_steps_hold, o_valid && (o_row != 6'd0),
                    $past(o_valid) && (o_wall_steps == $past(o_wall_steps)))
    // An accepted item makes the block busy
    `RGC_ASSERT_NXT(a_start_busy, start && !busy, busy)

endmodule

bind grid_raycast_column_renderer rgc_checker u_rgc_checker (.*);
